// ----- src/rwlt_pkg.sv -----
package rwlt_pkg;

  localparam int PROC_W  = 16;
  localparam int IDENT_W = 32;
  localparam int TID_W   = 16;
  localparam int CNT_W   = 16;
  localparam int MODE_W  = 2;
  localparam int SLOT_W  = 3;

  localparam logic [PROC_W-1:0] WILDCARD_PROC = '1;
  localparam logic [CNT_W-1:0]  CNT_MAX       = '1;

  // lock_mode bits
  localparam int MODE_EXCL_BIT = 0;
  localparam int MODE_KEEP_BIT = 1;

  typedef enum logic [1:0] {
    OP_ACQUIRE     = 2'd0,
    OP_RETRY       = 2'd1,
    OP_RELEASE     = 2'd2,
    OP_RELEASE_ALL = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_WAIT      = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    opcode_t              opcode;
    logic [PROC_W-1:0]    process_id;
    logic [IDENT_W-1:0]   lock_ident;
    logic [MODE_W-1:0]    lock_mode;
    logic [TID_W-1:0]     requester_tid;
  } rwlt_req_t;

  typedef struct packed {
    status_t              status;
    logic [SLOT_W-1:0]    slot_index;
    logic                 wake_shared;
    logic                 wake_exclusive;
  } rwlt_rsp_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic commit;
  } rwlt_cmd_t;

endpackage

// ----- src/rwlt_ram.sv -----
module rwlt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- src/rwlt_ctrl.sv -----
module rwlt_ctrl import rwlt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_stall,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rwlt_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_UPDATE
  } state_t;

  state_t state;

  assign req_stall   = (state != S_IDLE);
  assign cmd.capture = (state == S_IDLE) && req_valid;
  // result register must be free or draining before the update lands
  assign cmd.commit  = (state == S_UPDATE) && (!rsp_valid || !rsp_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req_valid) begin
            state <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          if (cmd.commit) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (cmd.commit) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  a_empty_out_commits: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPDATE && !rsp_valid) |=> rsp_valid)
    else $error("update with empty result register did not produce a word");

  a_commit_frees_input: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> (rsp_valid && !req_stall))
    else $error("commit did not present a word and reopen the input");

endmodule

// ----- src/rwlt_dpath.sv -----
module rwlt_dpath import rwlt_pkg::*; #(
  parameter int TABLE_ENTRIES = 8
) (
  input  logic      clk,
  input  logic      rst,
  input  rwlt_cmd_t cmd,
  input  rwlt_req_t req,
  output rwlt_rsp_t rsp
);

  localparam int IW = $clog2(TABLE_ENTRIES);

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CNT_W-1:0]  readers;
    logic              writer_valid;
    logic [TID_W-1:0]  writer_tid;
    logic [CNT_W-1:0]  waiters;
  } entry_t;

  // key part of the table, compared in parallel
  logic [TABLE_ENTRIES-1:0] used;
  logic [TABLE_ENTRIES-1:0] used_next;
  logic [IDENT_W-1:0]       ident [TABLE_ENTRIES];
  logic [PROC_W-1:0]        owner [TABLE_ENTRIES];

  logic [TABLE_ENTRIES-1:0] hit_vec;
  logic [TABLE_ENTRIES-1:0] owner_vec;
  logic                     found;
  logic                     any_free;
  logic [IW-1:0]            hit_idx;
  logic [IW-1:0]            free_idx;
  logic [IW-1:0]            look_idx;

  rwlt_req_t                req_q;
  logic                     found_q;
  logic                     any_free_q;
  logic [IW-1:0]            idx_q;

  logic [$bits(entry_t)-1:0] ram_rd;
  logic [$bits(entry_t)-1:0] ram_wr;
  logic                      ram_we;

  entry_t    ent;
  logic      locked;
  logic      alloc;
  logic      drop;
  logic      wr_entry;
  rwlt_rsp_t rsp_next;

  // lookup on the incoming word
  always_comb begin
    hit_idx  = '0;
    free_idx = '0;
    found    = 1'b0;
    any_free = 1'b0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      hit_vec[i] = used[i] && (ident[i] == req.lock_ident) &&
                   ((owner[i] == WILDCARD_PROC) || (owner[i] == req.process_id));
    end
    // lowest index wins
    for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
      if (hit_vec[i]) begin
        found   = 1'b1;
        hit_idx = IW'(i);
      end
      if (!used[i]) begin
        any_free = 1'b1;
        free_idx = IW'(i);
      end
    end
    look_idx = found ? hit_idx : free_idx;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q      <= req;
      found_q    <= found;
      any_free_q <= any_free;
      idx_q      <= look_idx;
    end
  end

  rwlt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (idx_q),
    .wr_data (ram_wr),
    .rd_en   (cmd.capture),
    .rd_addr (look_idx),
    .rd_data (ram_rd)
  );

  // update of the selected entry
  always_comb begin
    ent      = found_q ? entry_t'(ram_rd) : '0;
    locked   = 1'b0;
    alloc    = 1'b0;
    drop     = 1'b0;
    wr_entry = 1'b0;
    rsp_next = '{status: STATUS_DONE, slot_index: '0, wake_shared: 1'b0,
                 wake_exclusive: 1'b0};
    case (req_q.opcode) inside
      OP_ACQUIRE, OP_RETRY: begin
        if (!found_q && !any_free_q) begin
          rsp_next.status = STATUS_FULL;
        end else begin
          alloc               = !found_q;
          wr_entry            = 1'b1;
          rsp_next.slot_index = SLOT_W'(idx_q);
          if (req_q.opcode == OP_RETRY && ent.waiters != '0) begin
            ent.waiters = ent.waiters - CNT_W'(1);
          end
          locked = req_q.lock_mode[MODE_EXCL_BIT] ?
                   (ent.readers != '0 || ent.writer_valid) : ent.writer_valid;
          if (locked) begin
            rsp_next.status = STATUS_WAIT;
            if (ent.waiters != CNT_MAX) begin
              ent.waiters = ent.waiters + CNT_W'(1);
            end
          end else begin
            ent.mode = req_q.lock_mode;
            if (req_q.lock_mode[MODE_EXCL_BIT]) begin
              ent.writer_valid = 1'b1;
              ent.writer_tid   = req_q.requester_tid;
            end else if (ent.readers != CNT_MAX) begin
              ent.readers = ent.readers + CNT_W'(1);
            end
          end
        end
      end
      OP_RELEASE: begin
        if (!found_q) begin
          rsp_next.status = STATUS_NOT_FOUND;
        end else begin
          wr_entry            = 1'b1;
          rsp_next.slot_index = SLOT_W'(idx_q);
          if (ent.mode[MODE_EXCL_BIT]) begin
            ent.writer_valid = 1'b0;
          end else if (ent.readers != '0) begin
            ent.readers = ent.readers - CNT_W'(1);
          end
          if (ent.waiters != '0) begin
            rsp_next.wake_shared    = 1'b1;
            rsp_next.wake_exclusive = (ent.readers == '0);
          end else if (ent.readers == '0 && !ent.mode[MODE_KEEP_BIT]) begin
            drop = 1'b1;
          end
        end
      end
      default: begin
        // release all: only the used bits change
      end
    endcase
  end

  assign ram_we = cmd.commit && wr_entry;
  assign ram_wr = ent;

  always_comb begin
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      owner_vec[i] = (owner[i] == req_q.process_id);
    end
    used_next = used;
    if (alloc) begin
      used_next[idx_q] = 1'b1;
    end
    if (drop) begin
      used_next[idx_q] = 1'b0;
    end
    if (req_q.opcode == OP_RELEASE_ALL) begin
      used_next = used & ~owner_vec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (cmd.commit) begin
      used <= used_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && alloc) begin
      ident[idx_q] <= req_q.lock_ident;
      owner[idx_q] <= req_q.process_id;
    end
    if (cmd.commit) begin
      rsp <= rsp_next;
    end
  end

  a_alloc_marks_used: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && alloc) |=> used[$past(idx_q)])
    else $error("allocated entry not marked used");

  a_release_all_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit && req_q.opcode == OP_RELEASE_ALL) |=> ((used & owner_vec) == '0))
    else $error("release all left an entry of the process in use");

endmodule

// ----- src/reader_writer_lock_table_core.sv -----
// flow: the lookup (parallel ident compare and entry read) is registered when
//   a request word is taken; the update state, held while a full response
//   register stalls, then writes table and response; no new request until that
// reset: synchronous active-high rst marks every table entry free and empties
//   the response register; entry contents are left as they are
module reader_writer_lock_table_core import rwlt_pkg::*; #(
  parameter int TABLE_ENTRIES = 8
) (
  input  logic      clk,
  input  logic      rst,
  // request channel
  input  logic      req_valid,
  output logic      req_stall,
  input  rwlt_req_t req,
  // response channel
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rwlt_rsp_t rsp
);

  // capture: request word taken and lookup registered
  // commit: table update and response word written
  rwlt_cmd_t cmd;

  // controller: idle / update sequencing and the response valid flag
  rwlt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .cmd       (cmd)
  );

  // datapath: key flops with parallel match, counter ram, update logic and
  // the response register
  rwlt_dpath #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_dpath (
    .clk (clk),
    .rst (rst),
    .cmd (cmd),
    .req (req),
    .rsp (rsp)
  );

endmodule

// ----- tb/sv/tb.sv -----
module tb;
  import rwlt_pkg::*;

  localparam int ENTRIES    = 8;
  localparam int STALL_PCT  = 23;
  // cycles without any accepted word before the run is declared hung
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_WAIT = 8;
  localparam int RUN_COUNT  = 16;

  logic      clk;
  logic      rst;
  logic      req_valid;
  logic      req_stall;
  rwlt_req_t req;
  logic      rsp_valid;
  logic      rsp_stall;
  rwlt_rsp_t rsp;

  reader_writer_lock_table_core #(
    .TABLE_ENTRIES(ENTRIES)
  ) DUT (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req      (req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp      (rsp)
  );

  // shadow copy of the lock table
  logic                 tbl_used    [ENTRIES];
  logic [MODE_W-1:0]    tbl_mode    [ENTRIES];
  logic [IDENT_W-1:0]   tbl_ident   [ENTRIES];
  logic [PROC_W-1:0]    tbl_proc    [ENTRIES];
  logic [CNT_W-1:0]     tbl_readers [ENTRIES];
  logic                 tbl_writer  [ENTRIES];
  logic [TID_W-1:0]     tbl_tid     [ENTRIES];
  logic [CNT_W-1:0]     tbl_waiters [ENTRIES];

  // responses predicted for accepted requests, oldest first
  rwlt_rsp_t pending_rsp[$];

  int  errors;
  int  idle_cycles;
  // when set, neither side inserts bubbles or stalls
  bit  quiet;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // matching used entry (wildcard owner matches anyone), or -1;
  // vacant gets the lowest free entry or -1
  function automatic int find_slot(input logic [PROC_W-1:0] pid,
                                   input logic [IDENT_W-1:0] ident,
                                   output int vacant);
    vacant = -1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (!tbl_used[i]) begin
        if (vacant < 0) vacant = i;
      end else if (tbl_ident[i] == ident &&
                   (tbl_proc[i] == WILDCARD_PROC || tbl_proc[i] == pid)) begin
        return i;
      end
    end
    return -1;
  endfunction

  function automatic rwlt_rsp_t lock_table_step(input rwlt_req_t w);
    rwlt_rsp_t r;
    int        hit;
    int        vacant;
    logic      excl;
    logic      busy;
    r = '0;
    r.status = STATUS_DONE;
    excl = w.lock_mode[MODE_EXCL_BIT];
    case (w.opcode)
      OP_ACQUIRE, OP_RETRY: begin
        hit = find_slot(w.process_id, w.lock_ident, vacant);
        if (hit >= 0) begin
          // a retry first takes itself off the waiter count
          if (w.opcode == OP_RETRY && tbl_waiters[hit] != '0)
            tbl_waiters[hit] = tbl_waiters[hit] - 1'b1;
        end else if (vacant >= 0) begin
          hit = vacant;
          tbl_used[hit]    = 1'b1;
          tbl_ident[hit]   = w.lock_ident;
          tbl_proc[hit]    = w.process_id;
          tbl_readers[hit] = '0;
          tbl_writer[hit]  = 1'b0;
          tbl_tid[hit]     = '0;
          tbl_waiters[hit] = '0;
        end
        if (hit < 0) begin
          r.status = STATUS_FULL;
        end else begin
          r.slot_index = hit[SLOT_W-1:0];
          busy = excl ? (tbl_readers[hit] != '0 || tbl_writer[hit]) : tbl_writer[hit];
          if (busy) begin
            if (tbl_waiters[hit] != CNT_MAX) tbl_waiters[hit] = tbl_waiters[hit] + 1'b1;
            r.status = STATUS_WAIT;
          end else begin
            tbl_mode[hit] = w.lock_mode;
            if (excl) begin
              tbl_writer[hit] = 1'b1;
              tbl_tid[hit]    = w.requester_tid;
            end else if (tbl_readers[hit] != CNT_MAX) begin
              tbl_readers[hit] = tbl_readers[hit] + 1'b1;
            end
          end
        end
      end
      OP_RELEASE: begin
        hit = find_slot(w.process_id, w.lock_ident, vacant);
        if (hit < 0) begin
          r.status = STATUS_NOT_FOUND;
        end else begin
          r.slot_index = hit[SLOT_W-1:0];
          // the mode of the last grant decides what is dropped
          if (tbl_mode[hit][MODE_EXCL_BIT])
            tbl_writer[hit] = 1'b0;
          else if (tbl_readers[hit] != '0)
            tbl_readers[hit] = tbl_readers[hit] - 1'b1;
          if (tbl_waiters[hit] != '0) begin
            r.wake_shared    = 1'b1;
            r.wake_exclusive = (tbl_readers[hit] == '0);
          end else if (tbl_readers[hit] == '0 && !tbl_mode[hit][MODE_KEEP_BIT]) begin
            tbl_used[hit] = 1'b0;
          end
        end
      end
      default: begin
        // release all: exact owner compare, wildcard is not special here
        for (int i = 0; i < ENTRIES; i++)
          if (tbl_used[i] && tbl_proc[i] == w.process_id) tbl_used[i] = 1'b0;
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // request side
  // ---------------------------------------------------------------------------

  // drive one request word, hold it until accepted, then predict its response
  task automatic send_word(input opcode_t op, input logic [PROC_W-1:0] pid,
                           input logic [IDENT_W-1:0] ident, input logic [MODE_W-1:0] mode,
                           input logic [TID_W-1:0] tid);
    rwlt_req_t w;
    w.opcode        = op;
    w.process_id    = pid;
    w.lock_ident    = ident;
    w.lock_mode     = mode;
    w.requester_tid = tid;
    @(negedge clk);
    // random bubbles before the word goes out
    while (!quiet && $urandom_range(99) < STALL_PCT) begin
      req_valid <= 1'b0;
      @(negedge clk);
    end
    req_valid <= 1'b1;
    req       <= w;
    do @(posedge clk); while (req_stall);
    pending_rsp.push_back(lock_table_step(w));
  endtask

  // ---------------------------------------------------------------------------
  // response side
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    errors++;
  endtask

  always @(negedge clk)
    rsp_stall <= !quiet && ($urandom_range(99) < STALL_PCT);

  // compare each accepted response word with the oldest prediction
  always @(posedge clk) begin
    rwlt_rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("unexpected response word", 32'(rsp), '0);
      end else begin
        want = pending_rsp.pop_front();
        if (rsp.status != want.status)
          report_mismatch("status", 32'(rsp.status), 32'(want.status));
        if (rsp.slot_index != want.slot_index)
          report_mismatch("slot_index", 32'(rsp.slot_index), 32'(want.slot_index));
        if (rsp.wake_shared != want.wake_shared)
          report_mismatch("wake_shared", 32'(rsp.wake_shared), 32'(want.wake_shared));
        if (rsp.wake_exclusive != want.wake_exclusive)
          report_mismatch("wake_exclusive", 32'(rsp.wake_exclusive),
                          32'(want.wake_exclusive));
      end
    end
  end

  // hang detection: any accepted word on either channel resets the count
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // shared grant, blocked writer, wake on release, retry
  task automatic test_grant_and_wait();
    send_word(OP_ACQUIRE, 16'd1, 32'h0000_0000, 2'b00, 16'h0000);
    send_word(OP_ACQUIRE, 16'd1, 32'h0000_0000, 2'b01, 16'h1234);
    send_word(OP_RELEASE, 16'd1, 32'h0000_0000, 2'b00, 16'h0000);
    send_word(OP_RETRY,   16'd1, 32'h0000_0000, 2'b01, 16'hFFFF);
    send_word(OP_RETRY,   16'd1, 32'h0000_0000, 2'b00, 16'h0000);
    send_word(OP_RELEASE, 16'd1, 32'h0000_0000, 2'b01, 16'h0000);
    send_word(OP_RELEASE, 16'd1, 32'h0000_0000, 2'b01, 16'h0000);
  endtask

  // wildcard owner matches other processes and survives their release all
  task automatic test_wildcard_keep();
    send_word(OP_ACQUIRE, WILDCARD_PROC, 32'hFFFF_FFFF, 2'b11, 16'hA5A5);
    send_word(OP_ACQUIRE, 16'd7, 32'hFFFF_FFFF, 2'b10, 16'h5A5A);
    send_word(OP_RELEASE, 16'd7, 32'hFFFF_FFFF, 2'b00, 16'h0000);
    send_word(OP_RELEASE_ALL, 16'd7, 32'h0000_0000, 2'b00, 16'h0000);
    send_word(OP_ACQUIRE, 16'd0, 32'hFFFF_FFFF, 2'b00, 16'h0000);
    send_word(OP_RELEASE_ALL, WILDCARD_PROC, 32'hFFFF_FFFF, 2'b11, 16'hFFFF);
  endtask

  // fill every entry, then overflow and miss
  task automatic test_table_full();
    for (int i = 0; i < ENTRIES; i++)
      send_word(OP_ACQUIRE, 16'd2, 32'h8000_0000 | i, 2'($urandom_range(3)), 16'(i));
    send_word(OP_ACQUIRE, 16'd2, 32'h7FFF_FFFF, 2'b00, 16'h0000);
    send_word(OP_RETRY,   16'd9, 32'h8000_0000, 2'b01, 16'h0000);
    send_word(OP_RELEASE, 16'd9, 32'h1234_5678, 2'b00, 16'h0000);
    send_word(OP_RELEASE_ALL, 16'd2, 32'h0000_0000, 2'b00, 16'h0000);
  endtask

  // reader and waiter counts built up by a back-to-back run
  task automatic test_counter_buildup();
    quiet = 1'b1;
    for (int i = 0; i < RUN_COUNT; i++)
      send_word(OP_ACQUIRE, 16'd3, 32'h5A5A_0001, 2'b00, 16'h0000);
    for (int i = 0; i < RUN_COUNT; i++)
      send_word(OP_ACQUIRE, 16'd3, 32'h5A5A_0001, 2'b01, 16'(i));
    // readers remain, so only shared waiters get woken
    send_word(OP_RELEASE, 16'd3, 32'h5A5A_0001, 2'b00, 16'h0000);
    send_word(OP_RELEASE_ALL, 16'd3, 32'h0000_0000, 2'b00, 16'h0000);
    quiet = 1'b0;
  endtask

  // mostly coherent traffic over a few owners and idents, some pure noise
  task automatic test_random_traffic(input int count);
    logic [PROC_W-1:0]  pid_pool   [5];
    logic [IDENT_W-1:0] ident_pool [6];
    opcode_t            op;
    int                 pick;
    pid_pool   = '{16'd0, 16'd1, 16'd2, 16'h8000, WILDCARD_PROC};
    ident_pool = '{32'h0, 32'h1, 32'h2, 32'h8000_0000, 32'h1234_5678, 32'hFFFF_FFFF};
    for (int n = 0; n < count; n++) begin
      // a long run with no bubbles or stalls on either side
      quiet = (n >= 400 && n < 550);
      if ($urandom_range(99) < 10) begin
        send_word(opcode_t'($urandom_range(3)), 16'($urandom), $urandom,
                  2'($urandom_range(3)), 16'($urandom));
      end else begin
        pick = $urandom_range(99);
        if (pick < 35)      op = OP_ACQUIRE;
        else if (pick < 55) op = OP_RETRY;
        else if (pick < 94) op = OP_RELEASE;
        else                op = OP_RELEASE_ALL;
        send_word(op, pid_pool[$urandom_range(4)], ident_pool[$urandom_range(5)],
                  2'($urandom_range(3)), 16'($urandom));
      end
    end
    quiet = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    rsp_stall = 1'b0;
    quiet     = 1'b0;
    errors    = 0;
    for (int i = 0; i < ENTRIES; i++) begin
      tbl_used[i]    = 1'b0;
      tbl_mode[i]    = '0;
      tbl_ident[i]   = '0;
      tbl_proc[i]    = '0;
      tbl_readers[i] = '0;
      tbl_writer[i]  = 1'b0;
      tbl_tid[i]     = '0;
      tbl_waiters[i] = '0;
    end
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_grant_and_wait();
    test_wildcard_keep();
    test_table_full();
    test_counter_buildup();
    test_random_traffic(850);

    @(negedge clk);
    req_valid <= 1'b0;
    // drain outstanding responses, the watchdog guards this wait
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
